[rtl/msl_pkg.sv]
// shared constants and types for the motor slew limiter
`timescale 1ns / 1ps

package msl_pkg;

	localparam int LEVEL_W    = 16;
	localparam int TIME_W     = 32;
	localparam int STEP_W     = 15;
	localparam int PWM_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int Q_SHIFT    = 14;

	// accumulator width for magnitude times pwm span
	localparam int WACC_W = STEP_W + PWM_W + 1;
	localparam int DELTA_W = PWM_W + 1;

	typedef logic signed [LEVEL_W-1:0] level_t;

	localparam level_t FULL_POS = level_t'(16384);
	localparam level_t FULL_NEG = level_t'(-16384);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_PER_MS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_STOP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_FORWARD_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_BACKWARD_MAX = 3'd4;

	localparam logic [STEP_W-1:0] MAX_STEP_RST     = 15'd1638;
	localparam logic [STEP_W-1:0] ACCEL_RST        = 15'd16;
	localparam logic [PWM_W-1:0]  PWM_STOP_RST     = 12'd1500;
	localparam logic [PWM_W-1:0]  PWM_FORWARD_RST  = 12'd2000;
	localparam logic [PWM_W-1:0]  PWM_BACKWARD_RST = 12'd1000;

endpackage

[rtl/msl_if.sv]
// request and response channel interfaces of the motor slew limiter
`timescale 1ns / 1ps

interface msl_req_if;
	import msl_pkg::*;
	logic                valid;
	logic                ready;
	level_t              target;
	logic [TIME_W-1:0]   now_ms;
	modport source (output valid, target, now_ms, input ready);
	modport sink (input valid, target, now_ms, output ready);
endinterface

interface msl_rsp_if;
	import msl_pkg::*;
	logic                valid;
	logic                ready;
	logic [PWM_W-1:0]    pwm_width;
	logic                moved;
	level_t              level_now;
	modport source (output valid, pwm_width, moved, level_now, input ready);
	modport sink (input valid, pwm_width, moved, level_now, output ready);
endinterface

[rtl/motor_slew_limiter_pwm.sv]
// slew rate limited motor drive level with pwm pulse width output
// req carries a Q2.14 target and a millisecond timestamp; rsp returns one
// beat per request with the pulse width, a moved flag and the new level.
// cfg_we/cfg_idx/cfg_data write the five registers; write only while idle.
// each request runs from accept to rsp.valid through these steps: the
// bit-serial elapsed_ms * accel_per_ms product (one elapsed bit a cycle),
// the step, the width set-up, the bit-serial level * pwm span product, and
// the load of the output register.
// req.ready is high only while the sequencer is idle.
// the result sits in an output register, so the next request can be taken
// while rsp is stalled; the sequencer waits in its last cycle only when a
// second result is ready and the first has not been taken.
// reset clears the drive level, the last timestamp and the timing flag,
// restores the register defaults and drops rsp.valid.
`timescale 1ns / 1ps

module motor_slew_limiter_pwm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [msl_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [msl_pkg::CFG_DATA_W-1:0]  cfg_data,
	msl_req_if.sink                         req,
	msl_rsp_if.source                       rsp
);
	import msl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RATE  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_WIDTH = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [4:0] RATE_LAST  = 5'(TIME_W - 1);
	localparam logic [4:0] WIDTH_LAST = 5'(STEP_W - 1);

	logic [2:0]          state_q;
	logic [4:0]          cnt_q;

	logic [STEP_W-1:0]   max_step_q;
	logic [STEP_W-1:0]   accel_q;
	logic [PWM_W-1:0]    stop_q;
	logic [PWM_W-1:0]    fwd_q;
	logic [PWM_W-1:0]    bwd_q;

	level_t              level_q;
	logic [TIME_W-1:0]   last_q;
	logic                tv_q;

	level_t              tgt_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   ela_q;
	logic [STEP_W-1:0]   racc_q;
	logic                sat_q;
	logic                moved_q;
	logic [STEP_W-1:0]   mag_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic signed [WACC_W-1:0]  wacc_q;

	logic                rsp_valid_q;
	logic [PWM_W-1:0]    pwm_q;
	logic                rsp_moved_q;
	level_t              rsp_level_q;

	level_t              tgt_clamp;
	logic [STEP_W+1:0]   racc_next;
	logic signed [LEVEL_W:0] diff;
	logic [LEVEL_W:0]    dist_abs;
	logic [STEP_W-1:0]   allowed;
	level_t              level_step;
	logic [PWM_W-1:0]    span_end;
	logic signed [WACC_W-1:0]  wacc_next;
	logic signed [PWM_W+1:0]   width_sum;
	logic                out_free;

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.pwm_width = pwm_q;
	assign rsp.moved     = rsp_moved_q;
	assign rsp.level_now = rsp_level_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		if (req.target > FULL_POS) begin
			tgt_clamp = FULL_POS;
		end else if (req.target < FULL_NEG) begin
			tgt_clamp = FULL_NEG;
		end else begin
			tgt_clamp = req.target;
		end
	end

	// msb-first shift-add of elapsed time times accel, saturating past 15 bits
	assign racc_next = {1'b0, racc_q, 1'b0} + (ela_q[TIME_W-1] ? {2'b00, accel_q} : '0);

	always_comb begin
		diff = $signed({tgt_q[LEVEL_W-1], tgt_q}) - $signed({level_q[LEVEL_W-1], level_q});
		dist_abs = diff[LEVEL_W] ? -diff : diff;
		if (!tv_q || sat_q || racc_q > max_step_q) begin
			allowed = max_step_q;
		end else begin
			allowed = racc_q;
		end
		if (diff[LEVEL_W]) begin
			level_step = level_q - $signed({1'b0, allowed});
		end else begin
			level_step = level_q + $signed({1'b0, allowed});
		end
	end

	assign span_end  = level_q[LEVEL_W-1] ? bwd_q : fwd_q;
	assign wacc_next = (wacc_q <<< 1)
		+ (mag_q[STEP_W-1] ? WACC_W'(delta_q) : WACC_W'(0));
	// stop + floor(acc / 2^14)
	assign width_sum = $signed({2'b00, stop_q}) + $signed(wacc_q[WACC_W-1:Q_SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= MAX_STEP_RST;
			accel_q    <= ACCEL_RST;
			stop_q     <= PWM_STOP_RST;
			fwd_q      <= PWM_FORWARD_RST;
			bwd_q      <= PWM_BACKWARD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_STEP:         max_step_q <= cfg_data;
				REG_ACCEL_PER_MS:     accel_q    <= cfg_data;
				REG_PWM_STOP:         stop_q     <= cfg_data[PWM_W-1:0];
				REG_PWM_FORWARD_MAX:  fwd_q      <= cfg_data[PWM_W-1:0];
				REG_PWM_BACKWARD_MAX: bwd_q      <= cfg_data[PWM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			level_q     <= '0;
			last_q      <= '0;
			tv_q        <= 1'b0;
			tgt_q       <= '0;
			now_q       <= '0;
			ela_q       <= '0;
			racc_q      <= '0;
			sat_q       <= 1'b0;
			moved_q     <= 1'b0;
			mag_q       <= '0;
			delta_q     <= '0;
			wacc_q      <= '0;
			pwm_q       <= '0;
			rsp_moved_q <= 1'b0;
			rsp_level_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in the done state a free output register is reloaded below
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						tgt_q   <= tgt_clamp;
						now_q   <= req.now_ms;
						ela_q   <= req.now_ms - last_q;
						racc_q  <= '0;
						sat_q   <= 1'b0;
						cnt_q   <= RATE_LAST;
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					if (racc_next[STEP_W+1:STEP_W] != 2'b00) begin
						sat_q <= 1'b1;
					end
					racc_q <= racc_next[STEP_W-1:0];
					ela_q  <= ela_q << 1;
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (tgt_q == level_q) begin
						tv_q    <= 1'b0;
						moved_q <= 1'b0;
					end else begin
						if (dist_abs > {2'b00, allowed}) begin
							level_q <= level_step;
						end else begin
							level_q <= tgt_q;
						end
						last_q  <= now_q;
						tv_q    <= 1'b1;
						moved_q <= 1'b1;
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (level_q[LEVEL_W-1]) begin
						mag_q <= STEP_W'(LEVEL_W'(0) - level_q);
					end else begin
						mag_q <= level_q[STEP_W-1:0];
					end
					delta_q <= $signed({1'b0, span_end}) - $signed({1'b0, stop_q});
					wacc_q  <= '0;
					cnt_q   <= WIDTH_LAST;
					state_q <= ST_WIDTH;
				end
				ST_WIDTH: begin
					wacc_q <= wacc_next;
					mag_q  <= mag_q << 1;
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pwm_q       <= width_sum[PWM_W-1:0];
						rsp_moved_q <= moved_q;
						rsp_level_q <= level_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
